// ===== hdl/jed_pkg.sv =====
// shared types and constants of the joystick event decoder
package jed_pkg;

  // event codes carried on the result stream
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_UP    = 3'd1,
    EV_DOWN  = 3'd2,
    EV_LEFT  = 3'd3,
    EV_RIGHT = 3'd4,
    EV_SHORT = 3'd5,
    EV_LONG  = 3'd6
  } jed_event_t;

  localparam int CENTER_W = 12;
  localparam int DZ_W     = 12;
  localparam int MS_W     = 16;
  localparam int TIME_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int EVENT_W  = 3;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 3'd4;

  // register reset values
  localparam logic [CENTER_W-1:0] CENTER_RST   = 12'd1800;
  localparam logic [DZ_W-1:0]     DEADZONE_RST = 12'd300;
  localparam logic [MS_W-1:0]     REPEAT_RST   = 16'd250;
  localparam logic [MS_W-1:0]     DEBOUNCE_RST = 16'd30;
  localparam logic [MS_W-1:0]     LONG_RST     = 16'd500;

  typedef struct packed {
    logic [CENTER_W-1:0] center_level;
    logic [DZ_W-1:0]     deadzone;
    logic [MS_W-1:0]     repeat_ms;
    logic [MS_W-1:0]     debounce_ms;
    logic [MS_W-1:0]     long_press_ms;
  } jed_cfg_t;

endpackage

// ===== hdl/joystick_event_decoder_top.sv =====
// joystick event decoder top level: input stage, config registers, result register
//
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | vertical, horizontal, button, time
//  out_    | master    | out_tvalid/out_tready| event_code
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// one poll per cycle sustained while out_tready is high; a poll reaches out_ through
// the input register, then decode into the result register
// synchronous active-low reset puts the registers at their defaults and empties both stages
// out_tready low holds the result; the input stage still takes one more beat, then in_tready drops
// cfg_ready is always high
module joystick_event_decoder_top import jed_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // vertical_sample, horizontal_sample, button_level, time_ms, zero pad
  input  logic [((2*SAMPLE_BITS+1+TIME_W+7)/8)*8-1:0] in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // event_code, zero pad
  output logic [7:0]                   out_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int IN_W = ((2*SAMPLE_BITS+1+TIME_W+7)/8)*8;
  localparam int H_LO = SAMPLE_BITS;
  localparam int B_LO = 2*SAMPLE_BITS;
  localparam int T_LO = 2*SAMPLE_BITS + 1;

  jed_cfg_t         cfg_r;
  logic             s1_valid_r;
  logic [IN_W-1:0]  s1_data_r;
  logic             out_valid_r;
  jed_event_t       out_code_r;
  jed_event_t       core_code;
  logic             s1_adv, fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_level  <= CENTER_RST;
      cfg_r.deadzone      <= DEADZONE_RST;
      cfg_r.repeat_ms     <= REPEAT_RST;
      cfg_r.debounce_ms   <= DEBOUNCE_RST;
      cfg_r.long_press_ms <= LONG_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CENTER:   cfg_r.center_level  <= cfg_data[CENTER_W-1:0];
        CFG_DEADZONE: cfg_r.deadzone      <= cfg_data[DZ_W-1:0];
        CFG_REPEAT:   cfg_r.repeat_ms     <= cfg_data[MS_W-1:0];
        CFG_DEBOUNCE: cfg_r.debounce_ms   <= cfg_data[MS_W-1:0];
        CFG_LONG:     cfg_r.long_press_ms <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage moves on when the result register is free or draining
  assign s1_adv    = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
    end
  end

  jed_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (fire),
    .vertical_sample  (s1_data_r[SAMPLE_BITS-1:0]),
    .horizontal_sample(s1_data_r[H_LO +: SAMPLE_BITS]),
    .button_level     (s1_data_r[B_LO]),
    .time_ms          (s1_data_r[T_LO +: TIME_W]),
    .cfg              (cfg_r),
    .event_code       (core_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_code_r <= core_code;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8-EVENT_W){1'b0}}, out_code_r};

  // a decoded beat always lands in the result register
  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("decoded beat did not reach the result register");

  // a held input stage keeps its beat while the result is stalled
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_data_r))
    else $error("input stage lost or changed a stalled beat");

  // only defined event codes leave the block
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_code_r <= EV_LONG)
    else $error("undefined event code on the result");

endmodule

// ===== hdl/jed_core.sv =====
// direction decode, repeat timing, button debounce and press classification
module jed_core import jed_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  logic [SAMPLE_BITS-1:0] vertical_sample,
  input  logic [SAMPLE_BITS-1:0] horizontal_sample,
  input  logic                   button_level,
  input  logic [TIME_W-1:0]      time_ms,
  input  jed_cfg_t               cfg,
  output jed_event_t             event_code
);

  localparam int OFS_W = ((SAMPLE_BITS > CENTER_W) ? SAMPLE_BITS : CENTER_W) + 2;

  jed_event_t        prev_dir_r, prev_dir_nxt;
  logic [TIME_W-1:0] dir_start_r, dir_start_nxt;
  logic              stable_r, stable_nxt;
  logic              prev_raw_r, prev_raw_nxt;
  logic [TIME_W-1:0] raw_chg_r, raw_chg_nxt;
  logic [TIME_W-1:0] press_start_r, press_start_nxt;
  logic              long_rep_r, long_rep_nxt;

  logic signed [OFS_W-1:0] dv, dh, mag_v, mag_h, dz;
  jed_event_t        dir;
  logic              dir_changed, repeat_hit, debounce_hit, long_hit;
  logic [TIME_W-1:0] raw_chg_eff;

  assign dv    = $signed(OFS_W'(vertical_sample)) - $signed(OFS_W'(cfg.center_level));
  assign dh    = $signed(OFS_W'(horizontal_sample)) - $signed(OFS_W'(cfg.center_level));
  assign mag_v = dv[OFS_W-1] ? -dv : dv;
  assign mag_h = dh[OFS_W-1] ? -dh : dh;
  assign dz    = $signed(OFS_W'(cfg.deadzone));

  // vertical axis wins a tie
  always_comb begin
    dir = EV_NONE;
    if (mag_h > mag_v) begin
      if (dh > dz) dir = EV_RIGHT;
      else if (dh < -dz) dir = EV_LEFT;
    end else begin
      if (dv > dz) dir = EV_DOWN;
      else if (dv < -dz) dir = EV_UP;
    end
  end

  assign dir_changed = (dir != prev_dir_r);
  assign repeat_hit  = !dir_changed && (dir != EV_NONE) &&
                       ((time_ms - dir_start_r) > TIME_W'(cfg.repeat_ms));
  assign raw_chg_eff = (button_level != prev_raw_r) ? time_ms : raw_chg_r;
  assign debounce_hit = ((time_ms - raw_chg_eff) > TIME_W'(cfg.debounce_ms)) &&
                        (button_level != stable_r);
  assign long_hit     = !stable_r && !long_rep_r &&
                        ((time_ms - press_start_r) > TIME_W'(cfg.long_press_ms));

  always_comb begin
    prev_dir_nxt    = prev_dir_r;
    dir_start_nxt   = dir_start_r;
    stable_nxt      = stable_r;
    prev_raw_nxt    = prev_raw_r;
    raw_chg_nxt     = raw_chg_r;
    press_start_nxt = press_start_r;
    long_rep_nxt    = long_rep_r;
    event_code      = EV_NONE;
    if (dir_changed) begin
      prev_dir_nxt  = dir;
      dir_start_nxt = time_ms;
    end
    priority if (dir_changed && dir != EV_NONE) begin
      event_code = dir;
    end else if (repeat_hit) begin
      dir_start_nxt = time_ms;
      event_code    = dir;
    end else begin
      // button path runs only when no direction is reported
      prev_raw_nxt = button_level;
      raw_chg_nxt  = raw_chg_eff;
      if (debounce_hit) begin
        stable_nxt = button_level;
        if (!button_level) begin
          press_start_nxt = time_ms;
          long_rep_nxt    = 1'b0;
        end else if (!long_rep_r) begin
          event_code = EV_SHORT;
        end
      end else if (long_hit) begin
        long_rep_nxt = 1'b1;
        event_code   = EV_LONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_dir_r    <= EV_NONE;
      dir_start_r   <= '0;
      stable_r      <= 1'b1;
      prev_raw_r    <= 1'b1;
      raw_chg_r     <= '0;
      press_start_r <= '0;
      long_rep_r    <= 1'b0;
    end else if (fire) begin
      prev_dir_r    <= prev_dir_nxt;
      dir_start_r   <= dir_start_nxt;
      stable_r      <= stable_nxt;
      prev_raw_r    <= prev_raw_nxt;
      raw_chg_r     <= raw_chg_nxt;
      press_start_r <= press_start_nxt;
      long_rep_r    <= long_rep_nxt;
    end
  end

endmodule

// ===== verif/jed_event_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for the joystick event decoder: predicts one event per poll and compares
module jed_event_checker import jed_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int IN_W        = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [7:0]           out_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending
);

  // register copies
  logic [CENTER_W-1:0] rest_level;
  logic [DZ_W-1:0]     dead_band;
  logic [MS_W-1:0]     repeat_gap;
  logic [MS_W-1:0]     settle_gap;
  logic [MS_W-1:0]     hold_gap;

  // decoder state
  jed_event_t        prior_dir;
  logic [TIME_W-1:0] dir_start_ms;
  logic              btn_stable;
  logic              btn_raw_last;
  logic [TIME_W-1:0] raw_since;
  logic [TIME_W-1:0] press_since;
  logic              long_done;

  jed_event_t expected_events[$];

  function automatic jed_event_t decode_poll(input logic [SAMPLE_BITS-1:0] vs,
                                             input logic [SAMPLE_BITS-1:0] hs,
                                             input logic btn,
                                             input logic [TIME_W-1:0] now);
    int dv;
    int dh;
    int dz;
    int mag_v;
    int mag_h;
    jed_event_t dir;
    dv    = int'(vs) - int'(rest_level);
    dh    = int'(hs) - int'(rest_level);
    dz    = int'(dead_band);
    mag_v = dv < 0 ? -dv : dv;
    mag_h = dh < 0 ? -dh : dh;
    dir   = EV_NONE;
    // vertical wins a tie
    if (mag_h > mag_v) begin
      if (dh > dz) dir = EV_RIGHT;
      else if (dh < -dz) dir = EV_LEFT;
    end else begin
      if (dv > dz) dir = EV_DOWN;
      else if (dv < -dz) dir = EV_UP;
    end

    if (dir != prior_dir) begin
      prior_dir    = dir;
      dir_start_ms = now;
      if (dir != EV_NONE) return dir;
    end
    if (dir != EV_NONE && (now - dir_start_ms) > repeat_gap) begin
      dir_start_ms = now;
      return dir;
    end

    // a direction event above skips all of the button handling
    if (btn != btn_raw_last) begin
      raw_since    = now;
      btn_raw_last = btn;
    end
    if ((now - raw_since) > settle_gap && btn != btn_stable) begin
      btn_stable = btn;
      if (!btn_stable) begin
        press_since = now;
        long_done   = 1'b0;
      end else if (!long_done) begin
        return EV_SHORT;
      end
    end
    if (!btn_stable && !long_done && (now - press_since) > hold_gap) begin
      long_done = 1'b1;
      return EV_LONG;
    end
    return EV_NONE;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rest_level   = CENTER_RST;
      dead_band    = DEADZONE_RST;
      repeat_gap   = REPEAT_RST;
      settle_gap   = DEBOUNCE_RST;
      hold_gap     = LONG_RST;
      prior_dir    = EV_NONE;
      dir_start_ms = '0;
      btn_stable   = 1'b1;
      btn_raw_last = 1'b1;
      raw_since    = '0;
      press_since  = '0;
      long_done    = 1'b0;
      expected_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CENTER:   rest_level = cfg_data[CENTER_W-1:0];
          CFG_DEADZONE: dead_band  = cfg_data[DZ_W-1:0];
          CFG_REPEAT:   repeat_gap = cfg_data[MS_W-1:0];
          CFG_DEBOUNCE: settle_gap = cfg_data[MS_W-1:0];
          CFG_LONG:     hold_gap   = cfg_data[MS_W-1:0];
          default: ;
        endcase
      end
      // compare before pushing so a beat can never match its own prediction
      if (out_tvalid && out_tready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event beat, expected nothing, got %0d",
                   $time, out_tdata[EVENT_W-1:0]);
          fail_count++;
        end else begin
          jed_event_t want;
          want = expected_events.pop_front();
          if (out_tdata[EVENT_W-1:0] != want) begin
            $display("%0t: event_code mismatch, expected %0d, got %0d",
                     $time, want, out_tdata[EVENT_W-1:0]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_events.push_back(decode_poll(
          in_tdata[SAMPLE_BITS-1:0],
          in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS],
          in_tdata[2*SAMPLE_BITS],
          in_tdata[2*SAMPLE_BITS+TIME_W:2*SAMPLE_BITS+1]));
    end
    pending = expected_events.size();
  end

endmodule

// ===== verif/joystick_event_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the joystick event decoder: clock, reset, polls, config and verdict
module joystick_event_decoder_top_tb;
  import jed_pkg::*;

  localparam int SAMPLE_BITS = 12;
  localparam int SAMPLE_MAX  = 2**SAMPLE_BITS - 1;
  localparam int IN_W        = ((2*SAMPLE_BITS+1+TIME_W+7)/8)*8;
  localparam int STALL_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  // poll generator state
  int              cur_center = int'(CENTER_RST);
  int              cur_dz     = int'(DEADZONE_RST);
  int              stick_left = 0;
  int              btn_left   = 0;
  logic [SAMPLE_BITS-1:0] stick_v;
  logic [SAMPLE_BITS-1:0] stick_h;
  logic            btn_held;
  logic [TIME_W-1:0] poll_ms;

  joystick_event_decoder_top #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  jed_event_checker #(.SAMPLE_BITS(SAMPLE_BITS), .IN_W(IN_W)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] clamp_sample(input int x);
    if (x < 0) return '0;
    if (x > SAMPLE_MAX) return SAMPLE_BITS'(SAMPLE_MAX);
    return x[SAMPLE_BITS-1:0];
  endfunction

  // leaves in_tvalid high so back-to-back polls need no second assignment
  task automatic send_poll(input logic [SAMPLE_BITS-1:0] vs, input logic [SAMPLE_BITS-1:0] hs,
                           input logic btn, input logic [TIME_W-1:0] t);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({t, btn, hs, vs});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] center, input logic [CFG_DATA_W-1:0] dz,
                            input logic [CFG_DATA_W-1:0] rpt, input logic [CFG_DATA_W-1:0] db,
                            input logic [CFG_DATA_W-1:0] lng);
    wait_idle();
    cfg_write(CFG_CENTER, center);
    cfg_write(CFG_DEADZONE, dz);
    cfg_write(CFG_REPEAT, rpt);
    cfg_write(CFG_DEBOUNCE, db);
    cfg_write(CFG_LONG, lng);
    cfg_valid <= 1'b0;
    cur_center = int'(center[CENTER_W-1:0]);
    cur_dz     = int'(dz[DZ_W-1:0]);
  endtask

  // stick gestures and button holds last several polls so direction repeats,
  // debounce and long presses all get reached
  task automatic poll_random();
    int kind;
    int major;
    int minor;
    int step_sel;
    logic btn;
    if (stick_left == 0) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        stick_v = clamp_sample(cur_center + int'($urandom_range(0, 2*cur_dz)) - cur_dz);
        stick_h = clamp_sample(cur_center + int'($urandom_range(0, 2*cur_dz)) - cur_dz);
      end else if (kind < 9) begin
        // just at or just past the deadzone edge now and then
        if ($urandom_range(0, 4) == 0) major = cur_dz + int'($urandom_range(0, 1));
        else major = cur_dz + 1 + int'($urandom_range(0, 700));
        minor = ($urandom_range(0, 9) == 0) ? major : int'($urandom_range(0, major));
        if ($urandom_range(0, 1)) major = -major;
        if ($urandom_range(0, 1)) minor = -minor;
        if ($urandom_range(0, 1)) begin
          stick_v = clamp_sample(cur_center + major);
          stick_h = clamp_sample(cur_center + minor);
        end else begin
          stick_v = clamp_sample(cur_center + minor);
          stick_h = clamp_sample(cur_center + major);
        end
      end else begin
        stick_v = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        stick_h = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
      end
      stick_left = $urandom_range(1, 8);
    end
    stick_left--;
    if (btn_left == 0) begin
      btn_held = 1'($urandom_range(0, 1));
      btn_left = $urandom_range(1, 12);
    end
    btn_left--;
    // occasional single-poll contact bounce
    btn = btn_held ^ ($urandom_range(0, 9) == 0);
    step_sel = $urandom_range(0, 99);
    if (step_sel < 80) poll_ms += $urandom_range(0, 40);
    else if (step_sel < 92) poll_ms += $urandom_range(41, 1000);
    else if (step_sel < 97) poll_ms += $urandom_range(1001, 100000);
    else poll_ms = $urandom();
    send_poll(stick_v, stick_h, btn, poll_ms);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed polls at the reset settings
    send_poll(1800, 1800, 1'b1, 0);
    send_poll(0, 2000, 1'b1, 1);
    send_poll(0, 1800, 1'b1, 2);
    send_poll(4095, 1800, 1'b1, 3);
    send_poll(1800, 4095, 1'b1, 4);
    send_poll(1800, 0, 1'b1, 5);
    send_poll(2200, 2200, 1'b1, 6);        // tie, vertical wins
    send_poll(1400, 1400, 1'b1, 7);
    send_poll(2100, 1800, 1'b1, 8);        // exactly on the deadzone edge
    send_poll(2101, 1800, 1'b1, 9);
    send_poll(2101, 1800, 1'b1, 300);      // held long enough to repeat
    send_poll(1800, 1800, 1'b1, 301);
    send_poll(1800, 1800, 1'b0, 302);
    send_poll(1800, 1800, 1'b0, 333);      // press settles
    send_poll(1800, 1800, 1'b1, 340);
    send_poll(1800, 1800, 1'b1, 371);      // short press
    send_poll(1800, 1800, 1'b0, 400);
    send_poll(1800, 1800, 1'b0, 431);
    send_poll(1800, 1800, 1'b0, 932);      // long press
    send_poll(1800, 1800, 1'b1, 940);
    send_poll(1800, 1800, 1'b1, 980);      // release after long gives nothing
    send_poll(4095, 0, 1'b1, 32'hFFFF_FFFF);
    send_poll(4095, 0, 1'b0, 32'h0000_0010); // time wraps past zero
    send_poll(0, 4095, 1'b0, 32'h8000_0000);
    poll_ms = 32'h0001_0000;

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: begin
          // only the low bits of the narrow registers are kept; spare indexes are ignored
          set_config(16'hF800, 16'hF064, 100, 10, 200);
          @(posedge clk);
          for (int i = CFG_LONG + 1; i < 2**CFG_IDX_W; i++)
            cfg_write(CFG_IDX_W'(i), 16'hFFFF);
          cfg_valid <= 1'b0;
        end
        2: set_config(0, 0, 0, 0, 0);
        3: set_config(4095, 4095, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        4: set_config(CFG_DATA_W'($urandom_range(1000, 3000)),
                      CFG_DATA_W'($urandom_range(0, 800)),
                      CFG_DATA_W'($urandom_range(0, 400)),
                      CFG_DATA_W'($urandom_range(0, 60)),
                      CFG_DATA_W'($urandom_range(0, 800)));
        5: set_config(CFG_DATA_W'($urandom_range(0, 4095)),
                      CFG_DATA_W'($urandom_range(0, 300)),
                      CFG_DATA_W'($urandom_range(0, 65535)),
                      CFG_DATA_W'($urandom_range(0, 100)),
                      CFG_DATA_W'($urandom_range(0, 2000)));
        default: ;
      endcase
      for (int m = 0; m < 4; m++) begin
        case (m)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 86; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 86; end
          default: begin idle_pct = 11; stall_pct = 11; end
        endcase
        repeat (21) poll_random();
      end
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0t: %0d mismatches, %0d events never arrived", $time, fail_count, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/jed_pkg.sv
hdl/jed_core.sv
hdl/joystick_event_decoder_top.sv
verif/jed_event_checker.sv
verif/joystick_event_decoder_top_tb.sv
